// ===== sv/qcr_pkg.sv =====
// Package for the queued command retry block: shared types, codes and reset values.
// Used by qcr_front, qcr_back and the top level; depends on nothing.
`default_nettype none

package qcr_pkg;

   typedef enum logic [1:0] {
      KIND_PUMP    = 2'd0,
      KIND_ENQUEUE = 2'd1,
      KIND_ACK     = 2'd2,
      KIND_NONE    = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      PH_IDLE    = 3'd0,
      PH_PENDING = 3'd1,
      PH_WAITING = 3'd2,
      PH_DONE    = 3'd3,
      PH_GAVEUP  = 3'd4
   } phase_type;

   // CSR word index (paddr[3:2])
   localparam logic [1:0] REG_ACK_TIMEOUT  = 2'd0;
   localparam logic [1:0] REG_MAX_ATTEMPTS = 2'd1;
   localparam logic [1:0] REG_EXPECTED_CMD = 2'd2;

   localparam logic [15:0] RST_ACK_TIMEOUT  = 16'd700;
   localparam logic [7:0]  RST_MAX_ATTEMPTS = 8'd5;
   localparam logic [15:0] RST_EXPECTED_CMD = 16'd31010;

   localparam logic [7:0] ATTEMPT_SAT = 8'hFF;

   typedef struct packed {
      logic [15:0] ack_timeout_ms;
      logic [7:0]  max_attempts;
      logic [15:0] expected_command;
   } cfg_type;

   typedef struct packed {
      logic [31:0] east;
      logic [31:0] north;
      logic [31:0] alt;
   } drop_type;

   // classified request handed from front to back
   typedef struct packed {
      kind_type    kind;
      logic [31:0] now_ms;
      drop_type    drop;
      logic        ack_ok;
   } cmd_type;

   // result control held between execute and output register
   typedef struct packed {
      logic       send_cmd;
      logic [7:0] confirmation;
      phase_type  phase;
      logic       settled;
      logic       enqueue_rejected;
      logic       acked_event;
      logic       gave_up_event;
      logic       from_ram;
   } mid_type;

endpackage

`default_nettype wire

// ===== sv/qcr_ram.sv =====
// Generic single-write, single-read RAM with registered, enabled read.
// No dependencies.
`default_nettype none

module qcr_ram #(
   parameter int WIDTH = 96,
   parameter int DEPTH = 8
) (
   input  wire logic                                   clock,
   input  wire logic                                   we,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  wire logic [WIDTH-1:0]                       wdata,
   input  wire logic                                   re,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic      [WIDTH-1:0]                       rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ===== sv/qcr_front.sv =====
// Front end: classifies incoming requests and holds them in a two-entry queue.
// Depends on qcr_pkg.
`default_nettype none

module qcr_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire logic [1:0]       req_type,
   input  wire logic [31:0]      req_now_ms,
   input  wire logic [31:0]      req_drop_east,
   input  wire logic [31:0]      req_drop_north,
   input  wire logic [31:0]      req_drop_alt,
   input  wire logic [15:0]      req_ack_command,
   input  wire logic [7:0]       req_ack_result,
   input  wire qcr_pkg::cfg_type cfg,
   output logic                  cmd_valid,
   input  wire logic             cmd_take,
   output qcr_pkg::cmd_type      cmd
);
   import qcr_pkg::*;

   cmd_type    slot_ff [2];
   cmd_type    entry_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       push;
   logic       pop;

   always_comb begin
      entry_in.kind       = kind_type'(req_type);
      entry_in.now_ms     = req_now_ms;
      entry_in.drop.east  = req_drop_east;
      entry_in.drop.north = req_drop_north;
      entry_in.drop.alt   = req_drop_alt;
      // ack counts only for the expected command with an accepted result
      entry_in.ack_ok     = (req_ack_command == cfg.expected_command) &&
                            (req_ack_result == 8'd0);
   end

   assign req_stall = (fill_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign cmd_valid = (fill_ff != 2'd0);
   assign pop       = cmd_valid && cmd_take;
   assign cmd       = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= entry_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/qcr_back.sv =====
// Back end: executes classified requests against the drop FIFO and retry state,
// then registers one result per request. Depends on qcr_pkg and qcr_ram.
`default_nettype none

module qcr_back #(
   parameter int QUEUE_DEPTH = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire qcr_pkg::cfg_type cfg,
   input  wire logic             cmd_valid,
   output logic                  cmd_take,
   input  wire qcr_pkg::cmd_type cmd,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output logic                  rsp_send_cmd,
   output logic [7:0]            rsp_confirmation,
   output logic [31:0]           rsp_out_east,
   output logic [31:0]           rsp_out_north,
   output logic [31:0]           rsp_out_alt,
   output logic [2:0]            rsp_phase,
   output logic                  rsp_settled,
   output logic                  rsp_enqueue_rejected,
   output logic                  rsp_acked_event,
   output logic                  rsp_gave_up_event
);
   import qcr_pkg::*;

   localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(QUEUE_DEPTH);

   phase_type        phase_ff, phase_in;
   logic [7:0]       attempt_ff, attempt_in;
   logic [31:0]      sent_time_ff, sent_time_in;
   logic [IDX_W-1:0] head_ff, head_in;
   logic [IDX_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;
   drop_type         active_ff;

   mid_type          mid_ff, mid_in;
   logic             mid_valid_ff, mid_valid_in;

   logic             rsp_valid_ff, rsp_valid_in;
   mid_type          rsp_ff;
   drop_type         rsp_drop_ff, rsp_drop_in;

   logic             exec_go;
   logic             out_load;
   logic             ram_we;
   logic             ram_re;
   drop_type         ram_rdata;

   assign out_load = mid_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign exec_go  = cmd_valid && (!mid_valid_ff || out_load);
   assign cmd_take = exec_go;

   always_comb begin
      phase_type   cur;
      logic        go;
      logic [31:0] elapsed;

      cur          = phase_ff;
      go           = 1'b1;
      elapsed      = cmd.now_ms - sent_time_ff;
      phase_in     = phase_ff;
      attempt_in   = attempt_ff;
      sent_time_in = sent_time_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      ram_we       = 1'b0;
      ram_re       = 1'b0;
      mid_in       = '0;
      mid_in.phase = phase_ff;

      unique case (cmd.kind)
         KIND_PUMP: begin
            if (cur == PH_IDLE || cur == PH_DONE || cur == PH_GAVEUP) begin
               if (count_ff == '0) begin
                  phase_in = PH_IDLE;
                  go       = 1'b0;
               end else begin
                  // dequeue; the words come from the registered RAM read, taken by the output register
                  ram_re          = exec_go;
                  head_in         = (head_ff == LAST_SLOT) ? '0 : head_ff + 1'b1;
                  count_in        = count_ff - 1'b1;
                  attempt_in      = 8'd0;
                  mid_in.from_ram = 1'b1;
                  cur             = PH_PENDING;
               end
            end
            if (go && cur == PH_PENDING) begin
               mid_in.send_cmd     = 1'b1;
               mid_in.confirmation = mid_in.from_ram ? 8'd0 : attempt_ff;
               if (mid_in.from_ram) begin
                  attempt_in = 8'd1;
               end else if (attempt_ff != ATTEMPT_SAT) begin
                  attempt_in = attempt_ff + 8'd1;
               end
               sent_time_in = cmd.now_ms;
               phase_in     = PH_WAITING;
            end else if (go && cur == PH_WAITING) begin
               if (elapsed >= {16'd0, cfg.ack_timeout_ms}) begin
                  if (attempt_ff < cfg.max_attempts) begin
                     phase_in = PH_PENDING;
                  end else begin
                     phase_in             = PH_GAVEUP;
                     mid_in.gave_up_event = 1'b1;
                  end
               end
            end
         end
         KIND_ENQUEUE: begin
            if (count_ff == FULL_CNT) begin
               mid_in.enqueue_rejected = 1'b1;
            end else begin
               ram_we   = exec_go;
               tail_in  = (tail_ff == LAST_SLOT) ? '0 : tail_ff + 1'b1;
               count_in = count_ff + 1'b1;
            end
         end
         KIND_ACK: begin
            if (phase_ff == PH_WAITING && cmd.ack_ok) begin
               phase_in           = PH_DONE;
               mid_in.acked_event = 1'b1;
            end
         end
         KIND_NONE: begin
         end
         default: begin
         end
      endcase

      mid_in.phase   = phase_in;
      mid_in.settled = (phase_in != PH_PENDING) && (phase_in != PH_WAITING) &&
                       (count_in == '0);
   end

   qcr_ram #(
      .WIDTH($bits(drop_type)),
      .DEPTH(QUEUE_DEPTH)
   ) u_fifo_ram (
      .clock(clock),
      .we   (ram_we),
      .waddr(tail_ff),
      .wdata(cmd.drop),
      .re   (ram_re),
      .raddr(head_ff),
      .rdata(ram_rdata)
   );

   always_comb begin
      mid_valid_in = exec_go ? 1'b1 : (out_load ? 1'b0 : mid_valid_ff);
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
      if (!mid_ff.send_cmd) begin
         rsp_drop_in = '0;
      end else if (mid_ff.from_ram) begin
         rsp_drop_in = ram_rdata;
      end else begin
         rsp_drop_in = active_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         attempt_ff   <= 8'd0;
         sent_time_ff <= 32'd0;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         active_ff    <= '0;
         mid_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (exec_go) begin
            phase_ff     <= phase_in;
            attempt_ff   <= attempt_in;
            sent_time_ff <= sent_time_in;
            head_ff      <= head_in;
            tail_ff      <= tail_in;
            count_ff     <= count_in;
         end
         if (out_load && mid_ff.from_ram) begin
            active_ff <= ram_rdata;
         end
         mid_valid_ff <= mid_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (exec_go) begin
         mid_ff <= mid_in;
      end
      if (out_load) begin
         rsp_ff      <= mid_ff;
         rsp_drop_ff <= rsp_drop_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_send_cmd         = rsp_ff.send_cmd;
   assign rsp_confirmation     = rsp_ff.confirmation;
   assign rsp_out_east         = rsp_drop_ff.east;
   assign rsp_out_north        = rsp_drop_ff.north;
   assign rsp_out_alt          = rsp_drop_ff.alt;
   assign rsp_phase            = rsp_ff.phase;
   assign rsp_settled          = rsp_ff.settled;
   assign rsp_enqueue_rejected = rsp_ff.enqueue_rejected;
   assign rsp_acked_event      = rsp_ff.acked_event;
   assign rsp_gave_up_event    = rsp_ff.gave_up_event;

endmodule

`default_nettype wire

// ===== sv/queued_command_retry_with_ack.sv =====
// Top level of the queued drop command sender: CSR block, front queue and back end.
// Depends on qcr_pkg, qcr_front, qcr_back (and qcr_ram through qcr_back).
`default_nettype none

// Drop command sender with acknowledgement timeout and retransmission. Each request
// (pump with the current ms time, enqueue of a drop, or acknowledgement) yields exactly
// one result, in order. Sustained rate is one request per clock while rsp_stall is low; a
// request passes through the front queue, the execute stage and the output register.
// The execute stage updates the phase, attempt and FIFO pointers, and the drop FIFO is a
// RAM whose registered read is issued in the execute stage and taken by the output
// register. Drops are held in a FIFO of QUEUE_DEPTH entries; an enqueue into a full FIFO
// is dropped and flagged. Registers (APB, word addressed): 0x0 ack timeout in ms,
// 0x4 max attempts, 0x8 expected command id; write them only while no request is in flight.
module queued_command_retry_with_ack #(
   parameter int QUEUE_DEPTH = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_type,
   input  wire logic [31:0] req_now_ms,
   input  wire logic [31:0] req_drop_east,
   input  wire logic [31:0] req_drop_north,
   input  wire logic [31:0] req_drop_alt,
   input  wire logic [15:0] req_ack_command,
   input  wire logic [7:0]  req_ack_result,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_send_cmd,
   output logic [7:0]       rsp_confirmation,
   output logic [31:0]      rsp_out_east,
   output logic [31:0]      rsp_out_north,
   output logic [31:0]      rsp_out_alt,
   output logic [2:0]       rsp_phase,
   output logic             rsp_settled,
   output logic             rsp_enqueue_rejected,
   output logic             rsp_acked_event,
   output logic             rsp_gave_up_event,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [3:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);
   import qcr_pkg::*;

   cfg_type    cfg_ff;
   logic       csr_wr;
   logic [1:0] csr_idx;
   logic       cmd_valid;
   logic       cmd_take;
   cmd_type    cmd;

   assign pready  = 1'b1;
   assign csr_idx = paddr[3:2];
   assign csr_wr  = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ack_timeout_ms   <= RST_ACK_TIMEOUT;
         cfg_ff.max_attempts     <= RST_MAX_ATTEMPTS;
         cfg_ff.expected_command <= RST_EXPECTED_CMD;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_ACK_TIMEOUT:  cfg_ff.ack_timeout_ms   <= pwdata[15:0];
            REG_MAX_ATTEMPTS: cfg_ff.max_attempts     <= pwdata[7:0];
            REG_EXPECTED_CMD: cfg_ff.expected_command <= pwdata[15:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_ACK_TIMEOUT:  prdata = {16'd0, cfg_ff.ack_timeout_ms};
         REG_MAX_ATTEMPTS: prdata = {24'd0, cfg_ff.max_attempts};
         REG_EXPECTED_CMD: prdata = {16'd0, cfg_ff.expected_command};
         default:          prdata = 32'd0;
      endcase
   end

   qcr_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_type       (req_type),
      .req_now_ms     (req_now_ms),
      .req_drop_east  (req_drop_east),
      .req_drop_north (req_drop_north),
      .req_drop_alt   (req_drop_alt),
      .req_ack_command(req_ack_command),
      .req_ack_result (req_ack_result),
      .cfg            (cfg_ff),
      .cmd_valid      (cmd_valid),
      .cmd_take       (cmd_take),
      .cmd            (cmd)
   );

   qcr_back #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .cfg                 (cfg_ff),
      .cmd_valid           (cmd_valid),
      .cmd_take            (cmd_take),
      .cmd                 (cmd),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_send_cmd        (rsp_send_cmd),
      .rsp_confirmation    (rsp_confirmation),
      .rsp_out_east        (rsp_out_east),
      .rsp_out_north       (rsp_out_north),
      .rsp_out_alt         (rsp_out_alt),
      .rsp_phase           (rsp_phase),
      .rsp_settled         (rsp_settled),
      .rsp_enqueue_rejected(rsp_enqueue_rejected),
      .rsp_acked_event     (rsp_acked_event),
      .rsp_gave_up_event   (rsp_gave_up_event)
   );

   // a send always leaves the block waiting for its ack
   a_send_waits: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_send_cmd |-> rsp_phase == PH_WAITING)
      else $error("send result without waiting phase");

   a_no_send_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_send_cmd |-> rsp_confirmation == 8'd0 &&
         rsp_out_east == 32'd0 && rsp_out_north == 32'd0 && rsp_out_alt == 32'd0)
      else $error("request words leaked on a result without send");

   a_ack_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_acked_event |-> rsp_phase == PH_DONE && !rsp_send_cmd &&
         !rsp_gave_up_event)
      else $error("ack event without done phase");

   a_gave_up: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_gave_up_event |-> rsp_phase == PH_GAVEUP && !rsp_send_cmd)
      else $error("give-up event without gave-up phase");

   a_settled: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_settled |-> rsp_phase != PH_PENDING && rsp_phase != PH_WAITING)
      else $error("settled while a send is outstanding");

endmodule

`default_nettype wire

// ===== dv/queued_command_retry_with_ack_tb.sv =====
`timescale 1ns / 100ps
// Testbench for queued_command_retry_with_ack: directed and random drop, pump and ack
// requests checked against an in-bench model of the retry engine. Needs qcr_pkg and the RTL.

module queued_command_retry_with_ack_tb;
   import qcr_pkg::*;

   localparam int QUEUE_DEPTH  = 8;
   localparam int DRAIN_CYCLES = 8;
   localparam int CYCLE_LIMIT  = 600000;
   localparam int PHASE_ITEMS  = 72;
   localparam logic [1:0] REG_SPARE = 2'd3;

   typedef struct packed {
      logic       send_cmd;
      logic [7:0] confirmation;
      drop_type   words;
      logic [2:0] phase;
      logic       settled;
      logic       rejected;
      logic       acked;
      logic       gave_up;
   } outcome_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_type;
   logic [31:0] req_now_ms;
   logic [31:0] req_drop_east;
   logic [31:0] req_drop_north;
   logic [31:0] req_drop_alt;
   logic [15:0] req_ack_command;
   logic [7:0]  req_ack_result;
   logic        rsp_valid;
   logic        rsp_stall;
   logic        rsp_send_cmd;
   logic [7:0]  rsp_confirmation;
   logic [31:0] rsp_out_east;
   logic [31:0] rsp_out_north;
   logic [31:0] rsp_out_alt;
   logic [2:0]  rsp_phase;
   logic        rsp_settled;
   logic        rsp_enqueue_rejected;
   logic        rsp_acked_event;
   logic        rsp_gave_up_event;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [3:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   // model of the retry engine
   cfg_type     settings;
   phase_type   cur_phase;
   logic [7:0]  tries;
   logic [31:0] last_send_ms;
   drop_type    active_drop;
   drop_type    queued_drops[$];
   outcome_type expected_outcomes[$];

   outcome_type want_outcome;
   logic [31:0] now_track;
   int          mismatches;
   int          cycles;
   bit          idle_on;
   bit          stall_on;
   int          stall_hold;
   int          stall_draw;

   queued_command_retry_with_ack #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_top (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("queued_command_retry_with_ack regression: fail");
         $finish;
      end
   end

   function automatic outcome_type drop_command_outcome(kind_type kind, logic [31:0] now,
         drop_type drop, logic [15:0] ack_cmd, logic [7:0] ack_res);
      outcome_type o;
      phase_type   ph;
      logic [31:0] elapsed;
      logic        live;
      o = '0;
      case (kind)
         KIND_PUMP: begin
            ph   = cur_phase;
            live = 1'b1;
            if (ph == PH_IDLE || ph == PH_DONE || ph == PH_GAVEUP) begin
               if (queued_drops.size() == 0) begin
                  cur_phase = PH_IDLE;
                  live      = 1'b0;
               end else begin
                  active_drop = queued_drops[0];
                  queued_drops.delete(0);
                  tries       = '0;
                  ph          = PH_PENDING;
                  cur_phase   = PH_PENDING;
               end
            end
            if (live && ph == PH_PENDING) begin
               o.send_cmd     = 1'b1;
               o.confirmation = tries;
               o.words        = active_drop;
               if (tries != ATTEMPT_SAT) tries = tries + 8'd1;
               last_send_ms = now;
               cur_phase    = PH_WAITING;
            end else if (live && ph == PH_WAITING) begin
               // wrapping difference, so a timer rollover still times out
               elapsed = now - last_send_ms;
               if (elapsed >= {16'd0, settings.ack_timeout_ms}) begin
                  if (tries < settings.max_attempts) begin
                     cur_phase = PH_PENDING;
                  end else begin
                     cur_phase = PH_GAVEUP;
                     o.gave_up = 1'b1;
                  end
               end
            end
         end
         KIND_ENQUEUE: begin
            if (queued_drops.size() >= QUEUE_DEPTH) o.rejected = 1'b1;
            else queued_drops.insert(queued_drops.size(), drop);
         end
         KIND_ACK: begin
            if (cur_phase == PH_WAITING && ack_cmd == settings.expected_command
                  && ack_res == 8'd0) begin
               cur_phase = PH_DONE;
               o.acked   = 1'b1;
            end
         end
         default: ;
      endcase
      o.phase   = cur_phase;
      o.settled = cur_phase != PH_PENDING && cur_phase != PH_WAITING
                  && queued_drops.size() == 0;
      return o;
   endfunction

   function automatic drop_type random_drop();
      drop_type d;
      d.east  = $urandom;
      d.north = $urandom;
      d.alt   = $urandom;
      return d;
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_outcomes.size() == 0) begin
            $display("%0t: result with no request outstanding, expected none actual phase %0d",
                     $time, rsp_phase);
            mismatches++;
         end else begin
            want_outcome = expected_outcomes[0];
            expected_outcomes.delete(0);
            check_field("send_cmd", 32'(want_outcome.send_cmd), 32'(rsp_send_cmd));
            check_field("confirmation", 32'(want_outcome.confirmation),
                        32'(rsp_confirmation));
            check_field("out_east", want_outcome.words.east, rsp_out_east);
            check_field("out_north", want_outcome.words.north, rsp_out_north);
            check_field("out_alt", want_outcome.words.alt, rsp_out_alt);
            check_field("phase", 32'(want_outcome.phase), 32'(rsp_phase));
            check_field("settled", 32'(want_outcome.settled), 32'(rsp_settled));
            check_field("enqueue_rejected", 32'(want_outcome.rejected),
                        32'(rsp_enqueue_rejected));
            check_field("acked_event", 32'(want_outcome.acked), 32'(rsp_acked_event));
            check_field("gave_up_event", 32'(want_outcome.gave_up), 32'(rsp_gave_up_event));
         end
      end
   end

   // result side back-pressure: mostly free, short stalls, now and then a long one
   always @(negedge clock) begin
      if (stall_hold > 0) begin
         stall_hold--;
      end else if (!stall_on) begin
         rsp_stall <= 1'b0;
      end else begin
         stall_draw = $urandom_range(0, 99);
         if (stall_draw < 70) begin
            rsp_stall <= 1'b0;
         end else if (stall_draw < 96) begin
            rsp_stall <= 1'b1;
            stall_hold = $urandom_range(0, 2);
         end else begin
            rsp_stall <= 1'b1;
            stall_hold = $urandom_range(8, 40);
         end
      end
   end

   task automatic send_request(kind_type kind, logic [31:0] now, drop_type drop,
         logic [15:0] ack_cmd, logic [7:0] ack_res);
      int gap;
      int gap_draw;
      gap = 0;
      if (idle_on) begin
         gap_draw = $urandom_range(0, 99);
         if (gap_draw >= 95) gap = $urandom_range(8, 40);
         else if (gap_draw >= 65) gap = $urandom_range(1, 3);
      end
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_type        <= kind;
      req_now_ms      <= now;
      req_drop_east   <= drop.east;
      req_drop_north  <= drop.north;
      req_drop_alt    <= drop.alt;
      req_ack_command <= ack_cmd;
      req_ack_result  <= ack_res;
      do @(posedge clock); while (req_stall);
      expected_outcomes.insert(expected_outcomes.size(),
                               drop_command_outcome(kind, now, drop, ack_cmd, ack_res));
   endtask

   task automatic pump_at(logic [31:0] t);
      now_track = t;
      send_request(KIND_PUMP, t, random_drop(), 16'($urandom_range(0, 16'hFFFF)),
                   8'($urandom_range(0, 8'hFF)));
   endtask

   task automatic enqueue(drop_type drop);
      send_request(KIND_ENQUEUE, $urandom, drop, 16'($urandom_range(0, 16'hFFFF)),
                   8'($urandom_range(0, 8'hFF)));
   endtask

   task automatic acknowledge(logic [15:0] cmd, logic [7:0] res);
      send_request(KIND_ACK, $urandom, random_drop(), cmd, res);
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_outcomes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(logic [1:0] idx, logic [31:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      case (idx)
         REG_ACK_TIMEOUT:  settings.ack_timeout_ms   = value[15:0];
         REG_MAX_ATTEMPTS: settings.max_attempts     = value[7:0];
         REG_EXPECTED_CMD: settings.expected_command = value[15:0];
         default: ;
      endcase
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic apply_settings(logic [15:0] timeout_ms, logic [7:0] attempts,
         logic [15:0] cmd);
      drain_results();
      csr_write(REG_ACK_TIMEOUT, {16'd0, timeout_ms});
      csr_write(REG_MAX_ATTEMPTS, {24'd0, attempts});
      csr_write(REG_EXPECTED_CMD, {16'd0, cmd});
   endtask

   // reset settings: empty pump, unused kind, one full send / timeout / resend / ack cycle
   task automatic test_basic_flow();
      pump_at(32'd0);
      send_request(KIND_NONE, $urandom, random_drop(), 16'($urandom_range(0, 16'hFFFF)),
                   8'($urandom_range(0, 8'hFF)));
      enqueue('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
      acknowledge(settings.expected_command, 8'd0);     // not waiting: ignored
      pump_at(32'd100);
      acknowledge(settings.expected_command ^ 16'd1, 8'd0);
      acknowledge(settings.expected_command, 8'hFF);
      pump_at(32'd799);                                 // one ms short of the timeout
      pump_at(32'd800);
      pump_at(32'd801);
      acknowledge(settings.expected_command, 8'd0);
      pump_at(32'd900);
   endtask

   task automatic test_queue_full();
      enqueue('{32'd0, 32'd0, 32'd0});
      repeat (QUEUE_DEPTH) enqueue(random_drop());
   endtask

   task automatic test_timeout_edges();
      apply_settings(16'd0, 8'd0, RST_EXPECTED_CMD);
      csr_write(REG_SPARE, 32'hFFFF_FFFF);
      pump_at(32'h0000_1000);
      pump_at(32'h0000_1000);                           // zero attempts: first timeout gives up
      apply_settings(16'hFFFF, 8'hFF, 16'h0000);
      pump_at(32'hFFFF_FFF0);
      pump_at(32'h0000_FFEE);                           // elapsed wraps to one below timeout
      pump_at(32'h0000_FFEF);
      pump_at(32'h0000_FFEF);
      acknowledge(RST_EXPECTED_CMD, 8'd0);
      acknowledge(16'h0000, 8'd0);
   endtask

   // counter runs up to saturation, then the next timeout gives up
   task automatic test_retry_saturation();
      apply_settings(16'd0, 8'hFF, RST_EXPECTED_CMD);
      idle_on  = 1'b0;
      stall_on = 1'b0;
      repeat (2 * 255) pump_at(now_track);
      idle_on  = 1'b1;
      stall_on = 1'b1;
   endtask

   task automatic test_random_traffic();
      logic [15:0] timeouts[5];
      logic [7:0]  limits[5];
      logic [15:0] cmds[5];
      logic [31:0] delta;
      int          draw;
      timeouts = '{16'd700, 16'd1, 16'hFFFF, 16'd0, 16'd0};
      limits   = '{8'd5, 8'd1, 8'hFF, 8'd0, 8'd0};
      cmds     = '{RST_EXPECTED_CMD, 16'hFFFF, 16'h0000, 16'd0, 16'd0};
      timeouts[3] = 16'($urandom_range(2, 3000));
      limits[3]   = 8'($urandom_range(1, 6));
      cmds[3]     = 16'($urandom_range(0, 16'hFFFF));
      cmds[4]     = 16'($urandom_range(0, 16'hFFFF));
      for (int p = 0; p < 5; p++) begin
         apply_settings(timeouts[p], limits[p], cmds[p]);
         idle_on  = (p % 2) == 0;
         stall_on = p != 3;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n == PHASE_ITEMS / 2) drain_results();
            draw = $urandom_range(0, 99);
            if (draw < 40) begin
               case ($urandom_range(0, 9))
                  0:       delta = 32'd0;
                  1, 2, 3: delta = $urandom_range(0, settings.ack_timeout_ms);
                  4, 5, 6: delta = settings.ack_timeout_ms + $urandom_range(0, 2);
                  7, 8:    delta = settings.ack_timeout_ms + $urandom_range(0, 5000);
                  default: delta = $urandom;
               endcase
               pump_at(now_track + delta);
            end else if (draw < 62) begin
               enqueue(random_drop());
            end else if (draw < 90) begin
               case ($urandom_range(0, 7))
                  0:       acknowledge(16'($urandom_range(0, 16'hFFFF)),
                                       8'($urandom_range(0, 8'hFF)));
                  1:       acknowledge(settings.expected_command,
                                       8'($urandom_range(1, 8'hFF)));
                  default: acknowledge(settings.expected_command, 8'd0);
               endcase
            end else begin
               send_request(KIND_NONE, $urandom, random_drop(),
                            16'($urandom_range(0, 16'hFFFF)), 8'($urandom_range(0, 8'hFF)));
            end
         end
      end
   endtask

   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_type        = KIND_PUMP;
      req_now_ms      = '0;
      req_drop_east   = '0;
      req_drop_north  = '0;
      req_drop_alt    = '0;
      req_ack_command = '0;
      req_ack_result  = '0;
      rsp_stall       = 1'b0;
      psel            = 1'b0;
      penable         = 1'b0;
      pwrite          = 1'b0;
      paddr           = '0;
      pwdata          = '0;
      settings.ack_timeout_ms   = RST_ACK_TIMEOUT;
      settings.max_attempts     = RST_MAX_ATTEMPTS;
      settings.expected_command = RST_EXPECTED_CMD;
      cur_phase    = PH_IDLE;
      tries        = '0;
      last_send_ms = '0;
      active_drop  = '0;
      now_track    = '0;
      mismatches   = 0;
      cycles       = 0;
      idle_on      = 1'b1;
      stall_on     = 1'b1;
      stall_hold   = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_basic_flow();
      test_queue_full();
      test_timeout_edges();
      test_retry_saturation();
      test_random_traffic();
      drain_results();

      if (mismatches == 0 && expected_outcomes.size() == 0) begin
         $display("queued_command_retry_with_ack regression: pass");
      end else begin
         $display("queued_command_retry_with_ack regression: fail");
      end
      $finish;
   end

endmodule

// ===== queued_command_retry_with_ack.f =====
sv/qcr_pkg.sv
sv/qcr_ram.sv
sv/qcr_front.sv
sv/qcr_back.sv
sv/queued_command_retry_with_ack.sv
dv/queued_command_retry_with_ack_tb.sv
